// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the frame encoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/fce_pkg.sv -----
// ----------------------------------------------------------------------------
// fce_pkg
// Types and constants shared by the frame encoder modules.
// ----------------------------------------------------------------------------
package fce_pkg;

    // Start-of-frame byte; also the seed of the running checksum.
    localparam logic [7:0] START_BYTE = 8'hFE;

    // Most bytes one item can produce: five header bytes and a checksum.
    localparam int MAX_BYTES = 6;

    typedef logic [$clog2(MAX_BYTES)-1:0] byte_idx_t;
    typedef logic [$clog2(MAX_BYTES+1)-1:0] byte_cnt_t;

    // Bytes produced by one accepted item, in send order from octet[0].
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] octet;
        byte_cnt_t                 count;
        logic                      closes;   // last byte is the checksum
    } byte_list_t;

    // Framer state as seen from outside, for checking.
    typedef struct packed {
        logic frame_open;
        logic remaining_zero;
    } framer_status_t;

endpackage

// ----- hw/rtl/fce_framer.sv -----
// ----------------------------------------------------------------------------
// fce_framer
// Frame state and the byte list that each accepted item produces.
// ----------------------------------------------------------------------------
module fce_framer import fce_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_fire,
    input  logic           start_req,
    input  logic [15:0]    msg_function,
    input  logic [15:0]    payload_length,
    input  logic [7:0]     data_byte,
    output byte_list_t     byte_list,
    output framer_status_t status
);

    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  check_reg, check_next;
    logic        open_reg, open_next;

    logic [7:0]  hdr_check;
    logic [7:0]  data_check;
    logic [15:0] remaining_dec;

    always_comb begin
        hdr_check = START_BYTE ^ msg_function[15:8] ^ msg_function[7:0]
                  ^ payload_length[15:8] ^ payload_length[7:0];
        data_check    = check_reg ^ data_byte;
        remaining_dec = remaining_reg - 16'd1;

        byte_list      = '0;
        remaining_next = remaining_reg;
        check_next     = check_reg;
        open_next      = open_reg;

        if (start_req) begin
            // A start abandons any open frame and writes the header.
            byte_list.octet[0] = START_BYTE;
            byte_list.octet[1] = msg_function[15:8];
            byte_list.octet[2] = msg_function[7:0];
            byte_list.octet[3] = payload_length[15:8];
            byte_list.octet[4] = payload_length[7:0];
            byte_list.octet[5] = hdr_check;
            if (payload_length == 16'd0) begin
                byte_list.count  = byte_cnt_t'(6);
                byte_list.closes = 1'b1;
                remaining_next   = 16'd0;
                check_next       = START_BYTE;
                open_next        = 1'b0;
            end else begin
                byte_list.count = byte_cnt_t'(5);
                remaining_next  = payload_length;
                check_next      = hdr_check;
                open_next       = 1'b1;
            end
        end else if (open_reg) begin
            byte_list.octet[0] = data_byte;
            if (remaining_dec == 16'd0) begin
                // Last payload byte: follow it with the checksum.
                byte_list.octet[1] = data_check;
                byte_list.count    = byte_cnt_t'(2);
                byte_list.closes   = 1'b1;
                remaining_next     = 16'd0;
                check_next         = START_BYTE;
                open_next          = 1'b0;
            end else begin
                byte_list.count = byte_cnt_t'(1);
                remaining_next  = remaining_dec;
                check_next      = data_check;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= 16'd0;
            check_reg     <= START_BYTE;
            open_reg      <= 1'b0;
        end else if (item_fire) begin
            remaining_reg <= remaining_next;
            check_reg     <= check_next;
            open_reg      <= open_next;
        end
    end

    assign status.frame_open     = open_reg;
    assign status.remaining_zero = (remaining_reg == 16'd0);

endmodule

// ----- hw/rtl/fce_serializer.sv -----
// ----------------------------------------------------------------------------
// fce_serializer
// Holds one item's byte list and sends it byte by byte through an output
// register.
// ----------------------------------------------------------------------------
module fce_serializer import fce_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  byte_list_t byte_list,
    output logic       in_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic [MAX_BYTES-1:0][7:0] octet_reg;
    byte_cnt_t                 count_reg, count_next;
    byte_cnt_t                 idx_reg, idx_next;
    logic                      closes_reg;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic       m_last_reg;

    logic avail;
    logic pop;
    logic last_pending;

    always_comb begin
        avail        = (idx_reg != count_reg);
        pop          = avail && (!m_valid_reg || m_tready);
        last_pending = (idx_reg + byte_cnt_t'(1)) == count_reg;
        in_ready     = !avail || (pop && last_pending);

        idx_next   = pop ? idx_reg + byte_cnt_t'(1) : idx_reg;
        count_next = count_reg;
        if (load) begin
            idx_next   = '0;
            count_next = byte_list.count;
        end

        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            octet_reg  <= byte_list.octet;
            closes_reg <= byte_list.closes;
        end
        if (pop) begin
            m_data_reg <= octet_reg[idx_reg[$bits(byte_idx_t)-1:0]];
            m_last_reg <= closes_reg && last_pending;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- hw/rtl/xor_checksum_frame_encoder_core.sv -----
// ----------------------------------------------------------------------------
// xor_checksum_frame_encoder_core
// Serial frame builder with an XOR checksum over header and payload bytes.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one item per transfer. With s_axis_tuser high the
// item opens a frame: the block sends 0xFE, the function code high byte first
// and the payload length high byte first. With s_axis_tuser low the item is
// one payload byte, sent unchanged. After the last payload byte (or right
// after the header when the length is zero) the checksum follows with
// m_axis_tlast high. The checksum is 0xFE XORed with the four header bytes
// after the start byte and every payload byte.
// A payload item with no frame open is dropped. A start item abandons any
// open frame without a checksum.
// Accepted items pass through the byte buffer into the output register.
// Payload items flow at one per cycle while the receiver keeps up; a start item
// occupies the byte buffer for five or six output transfers, and the next item
// is taken in the cycle the buffer's last byte moves into the output register.
// A stalled receiver holds the output register; the buffer then holds the
// remaining bytes and s_axis_tready stays low until it drains.
// Reset clears the frame state and empties the buffer and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xor_checksum_frame_encoder_core import fce_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // msg_function[15:0], payload_length[31:16],
                                        // data_byte[39:32]
    input  logic        s_axis_tuser,   // start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
    output logic        m_axis_tlast    // frame_end
);

    logic           s_fire;
    byte_list_t     byte_list;
    framer_status_t status;

    logic           open_consistent;
    logic           start_fire;
    logic           len_nz;

    // An item is taken whenever the byte buffer is empty or about to be.
    assign s_fire = s_axis_tvalid && s_axis_tready;

    fce_framer u_framer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_fire      (s_fire),
        .start_req      (s_axis_tuser),
        .msg_function   (s_axis_tdata[15:0]),
        .payload_length (s_axis_tdata[31:16]),
        .data_byte      (s_axis_tdata[39:32]),
        .byte_list      (byte_list),
        .status         (status)
    );

    fce_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_fire),
        .byte_list (byte_list),
        .in_ready  (s_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tlast   (m_axis_tlast)
    );

    assign open_consistent = (status.frame_open != status.remaining_zero);
    assign start_fire      = s_fire && s_axis_tuser;
    assign len_nz          = (s_axis_tdata[31:16] != 16'd0);

    // A frame is open exactly while payload bytes are still owed.
    `FCE_ASSERT_IMP(a_open_has_remaining, aclk, aresetn, 1'b1, open_consistent)

    // A start item leaves a frame open unless its length was zero.
    `FCE_ASSERT_NXT(a_start_opens, aclk, aresetn, start_fire, status.frame_open == $past(len_nz))

    // Whenever an item closes its frame, the framer is idle afterwards.
    `FCE_ASSERT_NXT(a_close_clears, aclk, aresetn, s_fire && byte_list.closes, !status.frame_open)

endmodule

// ----- verif/xor_checksum_frame_encoder_checker.sv -----
// ----------------------------------------------------------------------------
// xor_checksum_frame_encoder_checker
// Watches both streams of the frame encoder, forms the bytes each accepted
// item must produce and compares them in order with the bytes sent.
// ----------------------------------------------------------------------------
module xor_checksum_frame_encoder_checker import fce_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // msg_function[15:0], payload_length[31:16],
                                        // data_byte[39:32]
    input  logic        s_axis_tuser,   // start_req
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
    input  logic        m_axis_tlast,   // frame_end
    output int          fail_count,
    output int          pending_bytes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       closes;
    } frame_byte_t;

    // Bytes still owed by the encoder, oldest first.
    frame_byte_t tx_expected[$];

    // Encoder state as this side sees it.
    logic        enc_open;
    logic [15:0] enc_left;
    logic [7:0]  enc_check;

    initial begin
        fail_count    = 0;
        pending_bytes = 0;
    end

    task automatic push_byte(input logic [7:0] value, input logic closes);
        frame_byte_t b;
        b.value  = value;
        b.closes = closes;
        tx_expected.push_back(b);
    endtask

    task automatic close_frame();
        push_byte(enc_check, 1'b1);
        enc_open  = 1'b0;
        enc_left  = '0;
        enc_check = START_BYTE;
    endtask

    task automatic encode_item(input logic start, input logic [15:0] fn,
                               input logic [15:0] len, input logic [7:0] db);
        if (start) begin
            // A new header replaces whatever frame was open.
            push_byte(START_BYTE, 1'b0);
            push_byte(fn[15:8], 1'b0);
            push_byte(fn[7:0], 1'b0);
            push_byte(len[15:8], 1'b0);
            push_byte(len[7:0], 1'b0);
            enc_check = START_BYTE ^ fn[15:8] ^ fn[7:0] ^ len[15:8] ^ len[7:0];
            enc_left  = len;
            enc_open  = 1'b1;
            if (len == 16'd0)
                close_frame();
        end else if (enc_open) begin
            push_byte(db, 1'b0);
            enc_check = enc_check ^ db;
            enc_left  = enc_left - 16'd1;
            if (enc_left == 16'd0)
                close_frame();
        end
    endtask

    always @(posedge aclk) begin
        frame_byte_t want;
        if (!aresetn) begin
            enc_open  = 1'b0;
            enc_left  = '0;
            enc_check = START_BYTE;
            tx_expected.delete();
        end else begin
            // Output first: a byte leaving now never stems from an item taken now.
            if (m_axis_tvalid && m_axis_tready) begin
                if (tx_expected.size() == 0) begin
                    $error("unexpected byte: tx_byte %02h frame_end %0b",
                           m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end else begin
                    want = tx_expected.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $error("tx_byte mismatch: expected %02h, actual %02h",
                               want.value, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.closes) begin
                        $error("frame_end mismatch: expected %0b, actual %0b",
                               want.closes, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                encode_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                            s_axis_tdata[39:32]);
        end
        pending_bytes = tx_expected.size();
    end

endmodule

// ----- verif/tb_xor_checksum_frame_encoder_core.sv -----
// ----------------------------------------------------------------------------
// tb_xor_checksum_frame_encoder_core
// Drives header and payload items into the frame encoder: a directed set of
// edge cases, then random frames, truncated frames and stray bytes, with
// random idling on both streams and one long receiver stall. The checker
// beside the block predicts every byte and counts mismatches.
// ----------------------------------------------------------------------------
module tb_xor_checksum_frame_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ITEMS   = 470;
    localparam int QUIET_AFTER = 400;   // no idling on either side past this count
    localparam int HOLD_AT     = 150;
    localparam int DRAIN_AT    = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // msg_function[15:0], payload_length[31:16],
                                      // data_byte[39:32]
    logic        s_axis_tuser = 1'b0; // start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // tx_byte[7:0]
    logic        m_axis_tlast;        // frame_end

    int fail_count;
    int pending_bytes;
    int cycle_count = 0;

    // Stimulus-side view of the frame, used only to shape the traffic and to
    // count items that the block actually uses.
    logic        gen_open = 1'b0;
    logic [15:0] gen_left = '0;
    int          items_sent = 0;

    logic quiet = 1'b0;          // set for the final stretch of the run
    logic hold_request = 1'b0;   // asks the receiver for one long stall

    always #6 aclk = ~aclk;

    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

    xor_checksum_frame_encoder_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    xor_checksum_frame_encoder_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending_bytes (pending_bytes)
    );

    // Offers one item, with an optional idle burst in front of it, and
    // returns at the rising edge where it was accepted. The valid stays high
    // afterwards; the next call or an idle step decides what follows.
    task automatic send_item(input logic start, input logic [15:0] fn,
                             input logic [15:0] len, input logic [7:0] db);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= start;
        s_axis_tdata  <= {db, len, fn};
        do @(posedge aclk); while (!s_axis_tready);
        // Track the frame so that dropped bytes are not counted.
        if (start) begin
            items_sent++;
            gen_open = (len != 16'd0);
            gen_left = len;
        end else if (gen_open) begin
            items_sent++;
            gen_left = gen_left - 16'd1;
            if (gen_left == 16'd0)
                gen_open = 1'b0;
        end
    endtask

    // A header followed by some payload bytes; fewer than the length leaves
    // the frame open for the next header to abandon.
    task automatic send_frame(input logic [15:0] fn, input logic [15:0] len,
                              input int nbytes);
        send_item(1'b1, fn, len, 8'($urandom));
        repeat (nbytes)
            send_item(1'b0, 16'($urandom), 16'($urandom), 8'($urandom_range(0, 255)));
    endtask

    // Stops offering and waits until every predicted byte has left the block.
    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_bytes != 0)
            @(negedge aclk);
    endtask

    // Receiver: random stall bursts, one long counted stall on request, and
    // steady readiness once the run goes quiet.
    initial begin
        int stall_len;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_len = $urandom_range(1, 7);
                m_axis_tready <= 1'b0;
                repeat (stall_len - 1) @(negedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int          pick;
        int          nbytes;
        logic [15:0] fn;
        logic [15:0] len;
        logic        hold_done;
        logic        drain_done;

        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        send_item(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);   // payload with no frame: dropped
        send_item(1'b1, 16'hFFFF, 16'h0000, 8'h00);   // empty frame, checksum at once
        send_item(1'b1, 16'h0000, 16'h0000, 8'hFF);
        send_item(1'b1, 16'hA5C3, 16'h0001, 8'h00);   // single payload byte
        send_item(1'b0, 16'h0000, 16'h0000, 8'hFF);
        send_item(1'b1, 16'h1234, 16'h0003, 8'h00);   // abandoned by the next header
        send_item(1'b0, 16'hFFFF, 16'hFFFF, 8'h00);
        send_item(1'b0, 16'h0000, 16'h0000, 8'h80);
        send_item(1'b1, 16'h8001, 16'h0002, 8'h00);
        send_item(1'b0, 16'h0000, 16'h0000, 8'h01);
        send_item(1'b0, 16'h0000, 16'h0000, 8'h7F);
        send_item(1'b0, 16'h0000, 16'h0000, 8'h55);   // after the checksum: dropped
        send_item(1'b1, 16'hFFFF, 16'hFFFF, 8'h00);   // largest length, abandoned
        send_item(1'b0, 16'h0000, 16'h0000, 8'hAA);
        send_item(1'b0, 16'h0000, 16'h0000, 8'h5A);
        send_item(1'b1, 16'h00FF, 16'hFF00, 8'h00);
        send_item(1'b0, 16'h0000, 16'h0000, 8'h3C);
        send_item(1'b1, 16'hFF00, 16'h00FF, 8'h00);
        send_item(1'b1, 16'h7E7E, 16'h0001, 8'h00);
        send_item(1'b0, 16'h0000, 16'h0000, 8'hFE);

        // Random part: mostly complete frames, some cut short, some stray bytes.
        while (items_sent < NUM_ITEMS) begin
            if (items_sent >= HOLD_AT && !hold_done) begin
                // The receiver stalls while a long frame keeps coming in.
                hold_done    = 1'b1;
                hold_request = 1'b1;
                send_frame(16'($urandom), 16'd40, 40);
            end
            if (items_sent >= DRAIN_AT && !drain_done) begin
                drain_done = 1'b1;
                wait_drained();
            end
            if (items_sent >= QUIET_AFTER)
                quiet = 1'b1;

            pick = $urandom_range(0, 15);
            fn   = 16'($urandom);
            if (pick == 0) begin
                send_item(1'b0, 16'($urandom), 16'($urandom), 8'($urandom_range(0, 255)));
            end else if (pick == 1) begin
                // Any length at all; the frame is usually left open.
                len = 16'($urandom);
                send_frame(fn, len, $urandom_range(0, 6));
            end else if (pick == 2) begin
                len    = 16'($urandom_range(2, 10));
                nbytes = $urandom_range(0, len - 1);
                send_frame(fn, len, nbytes);
            end else begin
                if ($urandom_range(0, 9) == 0)
                    len = 16'($urandom_range(9, 40));
                else
                    len = 16'($urandom_range(0, 8));
                send_frame(fn, len, int'(len));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_bytes == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
